// ===== src/rmst_pkg.sv =====
// Shared constants and types for the range-maximum segment tree core.
`default_nettype none
package rmst_pkg;

    localparam int MAX_POSITIONS = 524288;
    localparam int STORE_DEPTH   = 4 * MAX_POSITIONS;
    localparam int STORE_AW      = $clog2(STORE_DEPTH);
    localparam int POS_W         = $clog2(MAX_POSITIONS) + 1;
    localparam int SIZE_W        = 20;
    localparam int IN_POS_W      = 21;
    localparam int DATA_W        = 32;
    localparam int S_TDATA_W     = 96;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_POSITIONS);
    localparam logic [DATA_W-1:0] EMPTY_MAX  = DATA_W'(-1000000007);
    localparam logic [DATA_W-1:0] MIN_VALUE  = {1'b1, {(DATA_W-1){1'b0}}};

    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    typedef logic [STORE_AW-1:0] node_t;
    typedef logic [POS_W-1:0]    pos_t;
    typedef logic [DATA_W-1:0]   data_t;

    function automatic data_t smax(data_t a, data_t b);
        return ($signed(a) > $signed(b)) ? a : b;
    endfunction

endpackage
`default_nettype wire

// ===== src/rmst_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module rmst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== src/range_max_segment_tree_core.sv =====
// Range-maximum segment tree: point update and range max query over one node store.
// Update: walks down the tree to the leaf, writes it, then climbs back up level by level,
//   each level a sibling read and a parent write on the store's two ports.
// Query: one store read per level along the two range edges.
// One word in flight; the next word is taken once the current one has finished.
// Reset (aresetn low, synchronous): a clearing pass writes zero to all 2^21 store
//   entries, one per cycle, before the first word is taken; size_reg resets to 524288.
`default_nettype none
module range_max_segment_tree_core
    import rmst_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output      logic                 s_tready,
    // position[20:0], value[52:21], left[73:53], right[94:74], zero fill
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // req_type[0]
    input  wire logic                 s_tuser,
    output      logic                 m_tvalid,
    input  wire logic                 m_tready,
    // max_value[31:0]
    output      logic [DATA_W-1:0]    m_tdata,
    input  wire logic                 cfg_valid,
    output      logic                 cfg_ready,
    input  wire logic [SIZE_W-1:0]    cfg_data
);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_U_DOWN, ST_U_RD, ST_U_WR,
        ST_Q_SPLIT, ST_Q_LEFT, ST_Q_RIGHT, ST_Q_FIN, ST_Q_OUT
    } state_t;

    state_t              state_reg, state_next;
    node_t               clr_reg, clr_next;
    logic [SIZE_W-1:0]   size_reg;
    node_t               node_reg, node_next;
    pos_t                lo_reg, lo_next, hi_reg, hi_next;
    node_t               rnode_reg, rnode_next;
    pos_t                rlo_reg, rlo_next, rhi_reg, rhi_next;
    pos_t                ql_reg, ql_next, qr_reg, qr_next;
    data_t               cur_reg, cur_next;
    data_t               acc_reg, acc_next;
    logic                qpend_reg, qpend_next;
    logic                m_valid_reg, m_valid_next;
    data_t               m_data_reg, m_data_next;

    logic                ram_we, ram_re;
    node_t               ram_waddr, ram_raddr;
    data_t               ram_wdata, ram_rdata;

    pos_t                nm1;
    logic signed [IN_POS_W-1:0] in_pos, in_l, in_r, l_clip, r_clip, nm1_s;
    logic [POS_W:0]      mid_sum;
    pos_t                mid;
    node_t               lchild, rchild, sib, parent, sib_par;
    logic                lo_ge_ql, hi_le_qr;
    data_t               up_max;

    rmst_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    always_comb begin
        if (size_reg == '0) begin
            nm1 = '0;
        end else if (size_reg > SIZE_W'(MAX_POSITIONS)) begin
            nm1 = POS_W'(MAX_POSITIONS - 1);
        end else begin
            nm1 = POS_W'(size_reg - SIZE_W'(1));
        end
    end

    assign nm1_s  = $signed(IN_POS_W'(nm1));
    assign in_pos = $signed(s_tdata[20:0]);
    assign in_l   = $signed(s_tdata[73:53]);
    assign in_r   = $signed(s_tdata[94:74]);
    assign l_clip = (in_l < 0) ? '0 : in_l;
    assign r_clip = (in_r > nm1_s) ? nm1_s : in_r;

    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid      = mid_sum[POS_W:1];
    assign lchild   = {node_reg[STORE_AW-2:0], 1'b1};
    assign rchild   = lchild + STORE_AW'(1);
    assign sib      = node_reg[0] ? node_reg + STORE_AW'(1) : node_reg - STORE_AW'(1);
    assign parent   = (node_reg - STORE_AW'(1)) >> 1;
    assign sib_par  = parent[0] ? parent + STORE_AW'(1) : parent - STORE_AW'(1);
    assign lo_ge_ql = (lo_reg >= ql_reg);
    assign hi_le_qr = (hi_reg <= qr_reg);
    assign up_max   = smax(cur_reg, ram_rdata);

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        node_next    = node_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        rnode_next   = rnode_reg;
        rlo_next     = rlo_reg;
        rhi_next     = rhi_reg;
        ql_next      = ql_reg;
        qr_next      = qr_reg;
        cur_next     = cur_reg;
        acc_next     = qpend_reg ? smax(acc_reg, ram_rdata) : acc_reg;
        qpend_next   = 1'b0;
        m_valid_next = m_valid_reg & ~m_tready;
        m_data_next  = m_data_reg;
        ram_we       = 1'b0;
        ram_waddr    = node_reg;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = node_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + STORE_AW'(1);
                if (&clr_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                node_next = '0;
                lo_next   = '0;
                hi_next   = nm1;
                if (s_tvalid) begin
                    if (s_tuser == REQ_UPDATE) begin
                        ql_next  = POS_W'(in_pos);
                        cur_next = s_tdata[52:21];
                        if (in_pos >= 0 && in_pos <= nm1_s) begin
                            state_next = ST_U_DOWN;
                        end
                    end else begin
                        ql_next = POS_W'(l_clip);
                        qr_next = POS_W'(r_clip);
                        if (l_clip > r_clip) begin
                            acc_next   = EMPTY_MAX;
                            state_next = ST_Q_OUT;
                        end else begin
                            acc_next   = (l_clip == 0 && r_clip == nm1_s) ? MIN_VALUE
                                                                         : EMPTY_MAX;
                            state_next = ST_Q_SPLIT;
                        end
                    end
                end
            end
            ST_U_DOWN: begin
                if (lo_reg == hi_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = node_reg;
                    ram_wdata = cur_reg;
                    state_next = (node_reg == '0) ? ST_IDLE : ST_U_RD;
                end else if (ql_reg <= mid) begin
                    node_next = lchild;
                    hi_next   = mid;
                end else begin
                    node_next = rchild;
                    lo_next   = mid + POS_W'(1);
                end
            end
            ST_U_RD: begin
                ram_re     = 1'b1;
                ram_raddr  = sib;
                state_next = ST_U_WR;
            end
            ST_U_WR: begin
                ram_we    = 1'b1;
                ram_waddr = parent;
                ram_wdata = up_max;
                cur_next  = up_max;
                node_next = parent;
                if (parent == '0) begin
                    state_next = ST_IDLE;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = sib_par;
                end
            end
            ST_Q_SPLIT: begin
                if (lo_ge_ql && hi_le_qr) begin
                    ram_re     = 1'b1;
                    ram_raddr  = node_reg;
                    qpend_next = 1'b1;
                    state_next = ST_Q_FIN;
                end else if (qr_reg <= mid) begin
                    node_next = lchild;
                    hi_next   = mid;
                end else if (ql_reg > mid) begin
                    node_next = rchild;
                    lo_next   = mid + POS_W'(1);
                end else begin
                    rnode_next = rchild;
                    rlo_next   = mid + POS_W'(1);
                    rhi_next   = hi_reg;
                    node_next  = lchild;
                    hi_next    = mid;
                    state_next = ST_Q_LEFT;
                end
            end
            ST_Q_LEFT: begin
                if (lo_ge_ql) begin
                    ram_re     = 1'b1;
                    ram_raddr  = node_reg;
                    qpend_next = 1'b1;
                    node_next  = rnode_reg;
                    lo_next    = rlo_reg;
                    hi_next    = rhi_reg;
                    state_next = ST_Q_RIGHT;
                end else if (ql_reg <= mid) begin
                    ram_re     = 1'b1;
                    ram_raddr  = rchild;
                    qpend_next = 1'b1;
                    node_next  = lchild;
                    hi_next    = mid;
                end else begin
                    node_next = rchild;
                    lo_next   = mid + POS_W'(1);
                end
            end
            ST_Q_RIGHT: begin
                if (hi_le_qr) begin
                    ram_re     = 1'b1;
                    ram_raddr  = node_reg;
                    qpend_next = 1'b1;
                    state_next = ST_Q_FIN;
                end else if (qr_reg > mid) begin
                    ram_re     = 1'b1;
                    ram_raddr  = lchild;
                    qpend_next = 1'b1;
                    node_next  = rchild;
                    lo_next    = mid + POS_W'(1);
                end else begin
                    node_next = lchild;
                    hi_next   = mid;
                end
            end
            ST_Q_FIN: begin
                state_next = ST_Q_OUT;
            end
            ST_Q_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = acc_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            qpend_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            size_reg    <= SIZE_RESET;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            qpend_reg   <= qpend_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                size_reg <= cfg_data;
            end
        end
        node_reg   <= node_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        rnode_reg  <= rnode_next;
        rlo_reg    <= rlo_next;
        rhi_reg    <= rhi_next;
        ql_reg     <= ql_next;
        qr_reg     <= qr_next;
        cur_reg    <= cur_next;
        acc_reg    <= acc_next;
        m_data_reg <= m_data_next;
    end

`ifndef SYNTHESIS
    a_no_rw_collide: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("store read and write hit the same entry");

    a_no_out_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !m_valid_reg)
        else $error("result word during clearing pass");

    a_pend_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        qpend_reg |-> (state_reg != ST_IDLE && state_reg != ST_Q_OUT))
        else $error("query read pending outside a query walk");

    a_update_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == REQ_UPDATE && !m_valid_reg) |=> !m_valid_reg)
        else $error("update produced a result word");
`endif

endmodule
`default_nettype wire
